@@ src/frg_pkg.sv @@
package frg_pkg;

  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_DONE
  } frg_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } frg_div_ctrl_t;

endpackage

@@ src/frg_divider.sv @@
module frg_divider #(
  parameter int DW = frg_pkg::WORD_BITS_DEF - 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DW-1:0]          dividend,
  input  logic [DW-1:0]          divisor,
  output frg_pkg::frg_div_ctrl_t ctrl,
  output logic [DW-1:0]          quotient,
  output logic [DW-1:0]          remainder
);
  import frg_pkg::*;

  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] dvs_r;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (!diff[DW]) begin
        rem_r <= diff[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end else if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end
  end

  assign ctrl.start = start;
  assign ctrl.busy  = busy_r;
  assign ctrl.done  = done_r;
  assign quotient   = quo_r;
  assign remainder  = rem_r;

endmodule

@@ src/fraction_reduce_gcd_core.sv @@
// Reduces a signed fraction to lowest terms.
// The input channel carries the numerator and denominator; the output channel
// carries the reduced numerator and the reduced denominator, which is always
// at least one. Each transfer on the input gives exactly one output transfer.
// A zero denominator passes the numerator through with a denominator of one.
// A value that is zero or negative becomes one and the other, if positive,
// passes through; these cases bypass the divider.
// When both values are positive, one shared restoring divider, one quotient
// bit per cycle, runs Euclid's remainder loop and then divides each value by
// the divisor found. An item takes k + 2 divisions for k remainder steps, at
// most 45 steps for full 32-bit operands; random full-width values average
// near 20 steps.
// in_tready is high only while no item is being worked on. The result waits
// in an output register, so the next input is taken while it is stalled.
// Reset clears the sequencer and the output valid flag; nothing else is kept.
module fraction_reduce_gcd_core #(
  parameter int WORD_BITS = frg_pkg::WORD_BITS_DEF,
  localparam int IN_BITS  = ((2 * WORD_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = ((2 * WORD_BITS - 1 + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // Fields from bit 0: numerator, denominator.
  input  logic [IN_BITS-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // Fields from bit 0: reduced_numerator, reduced_denominator.
  output logic [OUT_BITS-1:0] out_tdata
);
  import frg_pkg::*;

  localparam int DW = WORD_BITS - 1;

  frg_state_t state_r, state_nxt;

  logic [WORD_BITS-1:0] in_num;
  logic [WORD_BITS-1:0] in_den;
  logic                 in_fire;
  logic                 num_pos;
  logic                 den_pos;
  logic                 den_zero;

  logic [DW-1:0]        num_r;
  logic [DW-1:0]        den_r;
  logic [DW-1:0]        b_r;
  logic [DW-1:0]        g_r;
  logic [WORD_BITS-1:0] res_num_r;
  logic [DW-1:0]        res_den_r;
  logic                 out_valid_r;
  logic                 out_load;

  logic                 div_start;
  logic [DW-1:0]        div_dividend;
  logic [DW-1:0]        div_divisor;
  frg_div_ctrl_t        div_ctrl;
  logic [DW-1:0]        div_quo;
  logic [DW-1:0]        div_rem;

  assign in_num   = in_tdata[WORD_BITS-1:0];
  assign in_den   = in_tdata[2*WORD_BITS-1:WORD_BITS];
  assign in_fire  = in_tvalid && in_tready;
  assign num_pos  = !in_num[WORD_BITS-1] && (in_num != '0);
  assign den_pos  = !in_den[WORD_BITS-1] && (in_den != '0);
  assign den_zero = (in_den == '0);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  frg_divider #(.DW(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .ctrl      (div_ctrl),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (!den_zero && num_pos && den_pos) ? S_GCD : S_DONE;
        end
      end
      S_GCD: begin
        if (div_ctrl.done && (div_rem == '0)) begin
          state_nxt = S_DIVN;
        end
      end
      S_DIVN: begin
        if (div_ctrl.done) begin
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_ctrl.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = in_num[DW-1:0];
    div_divisor  = in_den[DW-1:0];
    case (state_r)
      S_IDLE: begin
        div_start = in_fire && !den_zero && num_pos && den_pos;
      end
      S_GCD: begin
        div_start = div_ctrl.done;
        if (div_rem == '0) begin
          div_dividend = num_r;
          div_divisor  = b_r;
        end else begin
          div_dividend = b_r;
          div_divisor  = div_rem;
        end
      end
      S_DIVN: begin
        div_start    = div_ctrl.done;
        div_dividend = den_r;
        div_divisor  = g_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          num_r <= in_num[DW-1:0];
          den_r <= in_den[DW-1:0];
          b_r   <= in_den[DW-1:0];
          if (den_zero) begin
            res_num_r <= in_num;
            res_den_r <= DW'(1);
          end else begin
            res_num_r <= num_pos ? in_num : WORD_BITS'(1);
            res_den_r <= den_pos ? in_den[DW-1:0] : DW'(1);
          end
        end
      end
      S_GCD: begin
        if (div_ctrl.done) begin
          if (div_rem == '0) begin
            g_r <= b_r;
          end else begin
            b_r <= div_rem;
          end
        end
      end
      S_DIVN: begin
        if (div_ctrl.done) begin
          res_num_r <= {1'b0, div_quo};
        end
      end
      S_DIVD: begin
        if (div_ctrl.done) begin
          res_den_r <= div_quo;
        end
      end
      default: ;
    endcase
  end

  logic [WORD_BITS-1:0] out_num_r;
  logic [DW-1:0]        out_den_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_num_r <= res_num_r;
      out_den_r <= res_den_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BITS'({out_den_r, out_num_r});

endmodule

@@ src/frg_checker.sv @@
module frg_checker #(
  parameter int WORD_BITS = frg_pkg::WORD_BITS_DEF,
  localparam int OUT_BITS = ((2 * WORD_BITS - 1 + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OUT_BITS-1:0] out_tdata
);
  import frg_pkg::*;

  logic [WORD_BITS-2:0] out_den;

  assign out_den = out_tdata[2*WORD_BITS-2:WORD_BITS];

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Output valid after reset.");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("Input ready right after a transfer.");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_den != '0))
    else $error("Reduced denominator is zero.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("Stalled output changed.");

endmodule

bind fraction_reduce_gcd_core frg_checker #(.WORD_BITS(WORD_BITS)) u_frg_checker (.*);
